// ===== hdl/weighted_random_pick_excluding_last_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the weighted pick block
// Concurrent checks, all clocked on i_clk and held off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_RANDOM_PICK_EXCLUDING_LAST_ASSERT_SVH
`define WEIGHTED_RANDOM_PICK_EXCLUDING_LAST_ASSERT_SVH

// Condition must hold at every edge
`define WRPEL_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Consequent must hold in the same cycle
`define WRPEL_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the next cycle
`define WRPEL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/wrpel_pkg.sv =====
// ----------------------------------------------------------------------------
// wrpel_pkg
// Shared types, constants and the class weight lookup for the weighted pick.
// ----------------------------------------------------------------------------
`default_nettype none

package wrpel_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int W_W         = 4;
    localparam int W_MAX       = 15;
    localparam int TOT_W       = $clog2(MAX_ENTRIES * W_MAX + 1);
    localparam int RAND_W      = 16;
    localparam int STEP_W      = $clog2(RAND_W);
    localparam int PICK_W      = 6;
    localparam int CLS_W       = 2;
    localparam int REG_IDX_W   = 2;

    // configuration register indexes
    localparam logic [REG_IDX_W-1:0] REG_WEIGHT_A = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_WEIGHT_B = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_WEIGHT_C = 2'd2;

    localparam logic [W_W-1:0] WEIGHT_A_RST = 4'd5;
    localparam logic [W_W-1:0] WEIGHT_B_RST = 4'd3;
    localparam logic [W_W-1:0] WEIGHT_C_RST = 4'd1;
    localparam logic [W_W-1:0] WEIGHT_OTHER = 4'd1;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_SELECT = 2'd2,
        CMD_RSVD   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        RES_DONE  = 2'd0,
        RES_SEL   = 2'd1,
        RES_EMPTY = 2'd2,
        RES_FULL  = 2'd3
    } t_res;

    typedef enum logic [1:0] {
        CLS_A     = 2'd0,
        CLS_B     = 2'd1,
        CLS_C     = 2'd2,
        CLS_OTHER = 2'd3
    } t_class;

    // action taken when a transaction is accepted
    typedef enum logic [2:0] {
        OP_NONE   = 3'd0,
        OP_CLEAR  = 3'd1,
        OP_APPEND = 3'd2,
        OP_FULL   = 3'd3,
        OP_EMPTY  = 3'd4,
        OP_SINGLE = 3'd5,
        OP_DRAW   = 3'd6
    } t_op;

    typedef struct packed {
        logic accept;
        t_op  op;
        logic div_start;
        logic walk_start;
        logic finish;
        logic load_out;
    } t_ctl;

    typedef struct packed {
        logic full;
        logic empty;
        logic single;
        logic scan_done;
        logic div_done;
        logic walk_done;
        logic found;
        logic div_nz;
    } t_dp_st;

    function automatic logic [W_W-1:0] class_weight(
        input logic [CLS_W-1:0] cls,
        input logic [W_W-1:0]   wa,
        input logic [W_W-1:0]   wb,
        input logic [W_W-1:0]   wc
    );
        logic [W_W-1:0] w;
        case (t_class'(cls))
            CLS_A:   w = wa;
            CLS_B:   w = wb;
            CLS_C:   w = wc;
            default: w = WEIGHT_OTHER;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/weighted_random_pick_excluding_last.sv =====
// Append, clear and unused commands, and a select on fewer than two entries, go
// straight to the done state. Select with N >= 2 entries makes two passes over
// the class table through its one read port and runs a 16-step remainder unit.
// One transaction is worked at a time; input is ready again the cycle after the
// result is loaded, and a loaded result waits while the next one is accepted.
// Synchronous active-low reset empties the table and restores weights 5/3/1.
// ----------------------------------------------------------------------------
// weighted_random_pick_excluding_last
// Weighted lottery over a table of classed entries, skipping the last pick.
// ----------------------------------------------------------------------------
`default_nettype none

module weighted_random_pick_excluding_last
    import wrpel_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_wr_en,
    input  wire logic [REG_IDX_W-1:0] i_cfg_index,
    input  wire logic [W_W-1:0]       i_cfg_data,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [23:0]          s_axis_tdata,  // priority_class[1:0], rand_value[17:2]
    input  wire logic [1:0]           s_axis_tuser,  // cmd[1:0]
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [7:0]                m_axis_tdata,  // picked_index[5:0]
    output logic [1:0]                m_axis_tuser   // status[1:0]
);

`include "weighted_random_pick_excluding_last_assert.svh"

    t_ctl              w_ctl;
    t_dp_st            w_st;
    logic [1:0]        w_status;
    logic [PICK_W-1:0] w_pick;

    wrpel_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .i_cmd     (t_cmd'(s_axis_tuser)),
        .o_s_ready (s_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .i_st      (w_st),
        .o_ctl     (w_ctl)
    );

    wrpel_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_class     (s_axis_tdata[CLS_W-1:0]),
        .i_rand      (s_axis_tdata[CLS_W+RAND_W-1:CLS_W]),
        .i_ctl       (w_ctl),
        .o_st        (w_st),
        .o_status    (w_status),
        .o_pick      (w_pick)
    );

    assign m_axis_tdata = {2'b00, w_pick};
    assign m_axis_tuser = w_status;

    `WRPEL_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input accepted while a transaction is in work")
    `WRPEL_ASSERT_IMP(a_walk_hits, w_ctl.finish && w_st.div_nz, w_st.found, "walk ended without reaching the draw target")
    `WRPEL_ASSERT_ALWAYS(a_ctl_strobes, $onehot0({w_ctl.accept, w_ctl.div_start, w_ctl.walk_start, w_ctl.finish, w_ctl.load_out}), "overlapping sequencer commands")

endmodule

`default_nettype wire

// ===== hdl/wrpel_ctrl.sv =====
// ----------------------------------------------------------------------------
// wrpel_ctrl
// Sequencer: decodes each transaction, steps a draw through scan, divide and
// walk, and hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module wrpel_ctrl
    import wrpel_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_s_valid,
    input  wire t_cmd   i_cmd,
    output logic        o_s_ready,
    output logic        o_m_valid,
    input  wire logic   i_m_ready,
    input  wire t_dp_st i_st,
    output t_ctl        o_ctl
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_DIV  = 5'b00100,
        S_WALK = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_m_valid, n_m_valid;
    t_op    w_op;

    always_comb begin
        case (i_cmd)
            CMD_CLEAR:  w_op = OP_CLEAR;
            CMD_APPEND: w_op = i_st.full ? OP_FULL : OP_APPEND;
            CMD_SELECT: begin
                if (i_st.empty) begin
                    w_op = OP_EMPTY;
                end else if (i_st.single) begin
                    w_op = OP_SINGLE;
                end else begin
                    w_op = OP_DRAW;
                end
            end
            default:    w_op = OP_NONE;
        endcase
    end

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        o_ctl.op = w_op;
        case (r_state)
            S_IDLE: begin
                if (i_s_valid) begin
                    o_ctl.accept = 1'b1;
                    n_state = (w_op == OP_DRAW) ? S_SCAN : S_DONE;
                end
            end
            S_SCAN: begin
                if (i_st.scan_done) begin
                    o_ctl.div_start = 1'b1;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (i_st.div_done) begin
                    o_ctl.walk_start = 1'b1;
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (i_st.walk_done) begin
                    o_ctl.finish = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // hold until the output register is free
                if (!r_m_valid || i_m_ready) begin
                    o_ctl.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_m_valid = r_m_valid;
        if (o_ctl.load_out) begin
            n_m_valid = 1'b1;
        end else if (i_m_ready) begin
            n_m_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
        end
    end

    assign o_s_ready = (r_state == S_IDLE);
    assign o_m_valid = r_m_valid;

endmodule

`default_nettype wire

// ===== hdl/wrpel_dp.sv =====
// ----------------------------------------------------------------------------
// wrpel_dp
// Datapath: class table memory, weight registers, table scan pipeline,
// bit-serial remainder unit and the result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module wrpel_dp
    import wrpel_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_wr_en,
    input  wire logic [REG_IDX_W-1:0] i_cfg_index,
    input  wire logic [W_W-1:0]       i_cfg_data,
    input  wire logic [CLS_W-1:0]     i_class,
    input  wire logic [RAND_W-1:0]    i_rand,
    input  wire t_ctl                 i_ctl,
    output t_dp_st                    o_st,
    output logic [1:0]                o_status,
    output logic [PICK_W-1:0]         o_pick
);

    logic [CLS_W-1:0] mem [MAX_ENTRIES];

    logic [W_W-1:0]    r_wa, r_wb, r_wc;
    logic [CNT_W-1:0]  r_count, r_last_id;

    // scan pipeline, shared by the summing pass and the walk
    logic              r_run, r_walk;
    logic [CNT_W-1:0]  r_addr;
    logic              r_rd_vld;
    logic [IDX_W-1:0]  r_rd_idx;
    logic [CLS_W-1:0]  r_rd_cls;

    logic [TOT_W-1:0]  r_total, r_total_all, r_acc, r_div;
    logic              r_any, r_excl, r_found;
    logic [IDX_W-1:0]  r_first, r_found_idx;

    // remainder unit
    logic              r_div_act;
    logic [STEP_W-1:0] r_dstep;
    logic [RAND_W-1:0] r_dvd;
    logic [TOT_W:0]    r_rem;

    logic [1:0]        r_res_status, r_out_status;
    logic [IDX_W-1:0]  r_res_pick;
    logic [PICK_W-1:0] r_out_pick;

    logic              w_issue, w_pass_end, w_cand, w_hit;
    logic [W_W-1:0]    w_weight;
    logic [TOT_W-1:0]  w_acc_nxt;
    logic [TOT_W+1:0]  w_target;
    logic [TOT_W:0]    w_rem_sh;
    logic              w_rem_ge;
    logic [IDX_W-1:0]  w_pick;

    assign w_issue    = r_run && !r_found && (r_addr < r_count);
    assign w_pass_end = r_run && (r_addr == r_count) && !r_rd_vld;
    assign w_weight   = class_weight(r_rd_cls, r_wa, r_wb, r_wc);
    assign w_cand     = (r_walk && !r_excl) ||
                        ((CNT_W'(r_rd_idx) + CNT_W'(1)) != r_last_id);
    assign w_acc_nxt  = r_acc + TOT_W'(w_weight);
    assign w_target   = {1'b0, r_rem} + (TOT_W+2)'(1);
    assign w_hit      = w_cand && (w_target <= (TOT_W+2)'(w_acc_nxt));
    assign w_rem_sh   = {r_rem[TOT_W-1:0], r_dvd[RAND_W-1]};
    assign w_rem_ge   = (w_rem_sh >= (TOT_W+1)'(r_div));
    assign w_pick     = r_found ? r_found_idx : r_first;

    always_comb begin
        o_st.full      = (r_count == CNT_W'(MAX_ENTRIES));
        o_st.empty     = (r_count == '0);
        o_st.single    = (r_count == CNT_W'(1));
        o_st.scan_done = w_pass_end && !r_walk;
        o_st.div_done  = r_div_act && (r_dstep == STEP_W'(RAND_W - 1));
        o_st.walk_done = r_run && r_walk && (r_found || w_pass_end);
        o_st.found     = r_found;
        o_st.div_nz    = (r_div != '0);
    end

    // table memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_ctl.accept && i_ctl.op == OP_APPEND) begin
            mem[r_count[IDX_W-1:0]] <= i_class;
        end
        r_rd_cls <= mem[r_addr[IDX_W-1:0]];
    end

    // architectural state and control flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wa      <= WEIGHT_A_RST;
            r_wb      <= WEIGHT_B_RST;
            r_wc      <= WEIGHT_C_RST;
            r_count   <= '0;
            r_last_id <= '0;
            r_run     <= 1'b0;
            r_walk    <= 1'b0;
            r_rd_vld  <= 1'b0;
            r_found   <= 1'b0;
            r_div_act <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    REG_WEIGHT_A: r_wa <= i_cfg_data;
                    REG_WEIGHT_B: r_wb <= i_cfg_data;
                    REG_WEIGHT_C: r_wc <= i_cfg_data;
                    default: ;
                endcase
            end

            if (i_ctl.accept) begin
                case (i_ctl.op)
                    OP_CLEAR: begin
                        r_count   <= '0;
                        r_last_id <= '0;
                    end
                    OP_APPEND: r_count   <= r_count + CNT_W'(1);
                    OP_SINGLE: r_last_id <= CNT_W'(1);
                    OP_DRAW: begin
                        r_run   <= 1'b1;
                        r_walk  <= 1'b0;
                        r_found <= 1'b0;
                    end
                    default: ;
                endcase
            end

            if (i_ctl.walk_start) begin
                r_run   <= 1'b1;
                r_walk  <= 1'b1;
                r_found <= 1'b0;
            end else if (o_st.scan_done || o_st.walk_done) begin
                r_run <= 1'b0;
            end

            r_rd_vld <= w_issue;

            if (r_rd_vld && r_walk && r_run && !r_found && w_hit) begin
                r_found <= 1'b1;
            end

            if (i_ctl.div_start) begin
                r_div_act <= 1'b1;
            end else if (o_st.div_done) begin
                r_div_act <= 1'b0;
            end

            if (i_ctl.finish) begin
                r_last_id <= CNT_W'(w_pick) + CNT_W'(1);
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.accept && i_ctl.op == OP_DRAW) begin
            r_addr      <= '0;
            r_dvd       <= i_rand;
            r_total     <= '0;
            r_total_all <= '0;
            r_any       <= 1'b0;
            r_first     <= '0;
        end else if (i_ctl.walk_start) begin
            r_addr <= '0;
            r_acc  <= '0;
        end else if (w_issue) begin
            r_addr <= r_addr + CNT_W'(1);
        end

        if (w_issue) begin
            r_rd_idx <= r_addr[IDX_W-1:0];
        end

        // summing pass: candidate total, total of all, first candidate
        if (r_rd_vld && r_run && !r_walk) begin
            r_total_all <= r_total_all + TOT_W'(w_weight);
            if (w_cand) begin
                r_total <= r_total + TOT_W'(w_weight);
                r_any   <= 1'b1;
                if (!r_any) begin
                    r_first <= r_rd_idx;
                end
            end
        end

        // walk: accumulate candidate weights until the target is reached
        if (r_rd_vld && r_run && r_walk && !r_found) begin
            if (w_cand) begin
                r_acc <= w_acc_nxt;
            end
            if (w_hit) begin
                r_found_idx <= r_rd_idx;
            end
        end

        // remainder of the random word, one quotient bit per cycle
        if (i_ctl.div_start) begin
            r_div   <= r_any ? r_total : r_total_all;
            r_excl  <= r_any;
            r_rem   <= '0;
            r_dstep <= '0;
            if (!r_any) begin
                r_first <= '0;
            end
        end else if (r_div_act) begin
            r_rem   <= w_rem_ge ? (w_rem_sh - (TOT_W+1)'(r_div)) : w_rem_sh;
            r_dvd   <= {r_dvd[RAND_W-2:0], 1'b0};
            r_dstep <= r_dstep + STEP_W'(1);
        end

        if (i_ctl.accept) begin
            r_res_pick <= '0;
            case (i_ctl.op)
                OP_FULL:   r_res_status <= RES_FULL;
                OP_EMPTY:  r_res_status <= RES_EMPTY;
                OP_SINGLE: r_res_status <= RES_SEL;
                default:   r_res_status <= RES_DONE;
            endcase
        end else if (i_ctl.finish) begin
            r_res_status <= RES_SEL;
            r_res_pick   <= w_pick;
        end

        if (i_ctl.load_out) begin
            r_out_status <= r_res_status;
            r_out_pick   <= PICK_W'(r_res_pick);
        end
    end

    assign o_status = r_out_status;
    assign o_pick   = r_out_pick;

endmodule

`default_nettype wire
